@@ hw/rtl/pcns_pkg.sv @@
// ----------------------------------------------------------------------------
// pcns_pkg
// Shared types, constants and helper functions for the periodic cell
// neighbor stencil core.
// ----------------------------------------------------------------------------
package pcns_pkg;

  localparam int COORD_W = 6;
  localparam int DIV_W   = 7;
  localparam int SLOT_W  = 4;
  localparam int CELL_W  = 18;
  localparam int WRAP_W  = 2;
  localparam int PLANE_W = 12;

  localparam logic [DIV_W-1:0]  MAX_DIVISIONS   = 7'd64;
  localparam logic [SLOT_W-1:0] STENCIL_SIZE_3D = 4'd13;
  localparam logic [SLOT_W-1:0] STENCIL_SIZE_2D = 4'd4;
  localparam logic [SLOT_W-1:0] LAST_SLOT_3D    = STENCIL_SIZE_3D - 4'd1;
  localparam logic [SLOT_W-1:0] LAST_SLOT_2D    = STENCIL_SIZE_2D - 4'd1;

  localparam logic [DIV_W-1:0] RESET_DIVISIONS = 7'd4;

  localparam logic [WRAP_W-1:0] WRAP_NONE = 2'b00;
  localparam logic [WRAP_W-1:0] WRAP_UP   = 2'b01;
  localparam logic [WRAP_W-1:0] WRAP_DOWN = 2'b11;

  typedef enum logic [1:0] {
    CFG_GRID_COLS   = 2'd0,
    CFG_GRID_ROWS   = 2'd1,
    CFG_GRID_LAYERS = 2'd2,
    CFG_THREE_D     = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic xp;
    logic xn;
    logic yp;
    logic yn;
  } step_t;

  typedef struct packed {
    logic [COORD_W-1:0] pos;
    logic [WRAP_W-1:0]  wrap;
  } axis_t;

  function automatic step_t stencil_step(input logic [SLOT_W-1:0] slot);
    step_t s;
    s = '0;
    unique case (slot)
      4'd0:    s = '{xp: 1'b1, xn: 1'b0, yp: 1'b0, yn: 1'b0};
      4'd1:    s = '{xp: 1'b1, xn: 1'b0, yp: 1'b1, yn: 1'b0};
      4'd2:    s = '{xp: 1'b0, xn: 1'b0, yp: 1'b1, yn: 1'b0};
      4'd3:    s = '{xp: 1'b0, xn: 1'b1, yp: 1'b1, yn: 1'b0};
      4'd4:    s = '{xp: 1'b1, xn: 1'b0, yp: 1'b0, yn: 1'b0};
      4'd5:    s = '{xp: 1'b1, xn: 1'b0, yp: 1'b1, yn: 1'b0};
      4'd6:    s = '{xp: 1'b0, xn: 1'b0, yp: 1'b1, yn: 1'b0};
      4'd7:    s = '{xp: 1'b0, xn: 1'b1, yp: 1'b1, yn: 1'b0};
      4'd8:    s = '{xp: 1'b0, xn: 1'b1, yp: 1'b0, yn: 1'b0};
      4'd9:    s = '{xp: 1'b0, xn: 1'b1, yp: 1'b0, yn: 1'b1};
      4'd10:   s = '{xp: 1'b0, xn: 1'b0, yp: 1'b0, yn: 1'b1};
      4'd11:   s = '{xp: 1'b1, xn: 1'b0, yp: 1'b0, yn: 1'b1};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic axis_t step_axis(input logic [COORD_W-1:0] pos,
                                      input logic up,
                                      input logic dn,
                                      input logic [DIV_W-1:0] n);
    axis_t a;
    logic [DIV_W-1:0] pos_inc;
    logic [DIV_W-1:0] n_dec;
    pos_inc = {1'b0, pos} + 7'd1;
    n_dec   = n - 7'd1;
    a.pos   = pos;
    a.wrap  = WRAP_NONE;
    if (up) begin
      if (pos_inc >= n) begin
        a.pos  = '0;
        a.wrap = WRAP_DOWN;
      end else begin
        a.pos = pos_inc[COORD_W-1:0];
      end
    end else if (dn) begin
      if (pos == '0) begin
        a.pos  = n_dec[COORD_W-1:0];
        a.wrap = WRAP_UP;
      end else begin
        a.pos = pos - 6'd1;
      end
    end
    return a;
  endfunction

  function automatic logic [DIV_W-1:0] clamp_div(input logic [DIV_W-1:0] v);
    return (v > MAX_DIVISIONS) ? MAX_DIVISIONS : v;
  endfunction

endpackage

@@ hw/rtl/pcns_in_if.sv @@
// ----------------------------------------------------------------------------
// pcns_in_if
// Request channel carrying one home cell coordinate.
// ----------------------------------------------------------------------------
interface pcns_in_if;
  logic                         valid;
  logic                         ready;
  logic [pcns_pkg::COORD_W-1:0] cell_col;
  logic [pcns_pkg::COORD_W-1:0] cell_row;
  logic [pcns_pkg::COORD_W-1:0] cell_layer;

  modport source (output valid, output cell_col, output cell_row, output cell_layer,
                  input ready);
  modport sink (input valid, input cell_col, input cell_row, input cell_layer,
                output ready);
endinterface

@@ hw/rtl/pcns_out_if.sv @@
// ----------------------------------------------------------------------------
// pcns_out_if
// Result channel carrying one neighbor cell request.
// ----------------------------------------------------------------------------
interface pcns_out_if;
  logic                                valid;
  logic                                ready;
  logic [pcns_pkg::SLOT_W-1:0]         slot;
  logic [pcns_pkg::CELL_W-1:0]         neighbor_cell;
  logic signed [pcns_pkg::WRAP_W-1:0]  wrap_x;
  logic signed [pcns_pkg::WRAP_W-1:0]  wrap_y;
  logic signed [pcns_pkg::WRAP_W-1:0]  wrap_z;
  logic                                last;
  logic                                bad_coordinate;

  modport source (output valid, output slot, output neighbor_cell, output wrap_x,
                  output wrap_y, output wrap_z, output last, output bad_coordinate,
                  input ready);
  modport sink (input valid, input slot, input neighbor_cell, input wrap_x,
                input wrap_y, input wrap_z, input last, input bad_coordinate,
                output ready);
endinterface

@@ hw/rtl/periodic_cell_neighbor_stencil_core.sv @@
// ----------------------------------------------------------------------------
// periodic_cell_neighbor_stencil_core
// Emits the half-shell neighbor cells of a home cell in a periodic grid.
// ----------------------------------------------------------------------------
// Each accepted cell produces 13 results in 3D mode, 4 in 2D mode, or a single
// error result when the coordinate lies outside the grid. One slot is issued
// per cycle through a single neighbor path while the output is not stalled,
// and the next cell is taken in the cycle its last slot is issued. A cell
// moves from the input register through the wrap and plane stage, and the
// index multiply stage feeds the output register. Grid size registers are
// written only while the block is idle: the user is bound to this, and the
// block itself does not enforce it.
module periodic_cell_neighbor_stencil_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [pcns_pkg::DIV_W-1:0]  cfg_wdata,
  pcns_in_if.sink                     in_chan,
  pcns_out_if.source                  out_chan
);

  logic [pcns_pkg::DIV_W-1:0] grid_cols_r;
  logic [pcns_pkg::DIV_W-1:0] grid_rows_r;
  logic [pcns_pkg::DIV_W-1:0] grid_layers_r;
  logic                       three_d_r;

  logic [pcns_pkg::DIV_W-1:0] cols_c;
  logic [pcns_pkg::DIV_W-1:0] rows_c;
  logic [pcns_pkg::DIV_W-1:0] lays_c;

  logic                         item_valid_r;
  logic [pcns_pkg::COORD_W-1:0] col_r;
  logic [pcns_pkg::COORD_W-1:0] row_r;
  logic [pcns_pkg::COORD_W-1:0] lay_r;
  logic [pcns_pkg::SLOT_W-1:0]  slot_r;

  logic                          a_valid_r;
  logic [pcns_pkg::SLOT_W-1:0]   a_slot_r;
  logic                          a_last_r;
  logic                          a_bad_r;
  logic [pcns_pkg::COORD_W-1:0]  a_nc_r;
  logic [pcns_pkg::PLANE_W-1:0]  a_plane_r;
  logic [pcns_pkg::WRAP_W-1:0]   a_wx_r;
  logic [pcns_pkg::WRAP_W-1:0]   a_wy_r;
  logic [pcns_pkg::WRAP_W-1:0]   a_wz_r;

  logic                          out_valid_r;
  logic [pcns_pkg::SLOT_W-1:0]   out_slot_r;
  logic [pcns_pkg::CELL_W-1:0]   out_cell_r;
  logic [pcns_pkg::WRAP_W-1:0]   out_wx_r;
  logic [pcns_pkg::WRAP_W-1:0]   out_wy_r;
  logic [pcns_pkg::WRAP_W-1:0]   out_wz_r;
  logic                          out_last_r;
  logic                          out_bad_r;

  logic                          adv;
  logic                          bad_c;
  logic                          last_c;
  logic                          issue;
  logic                          accept;
  pcns_pkg::step_t               step_c;
  pcns_pkg::axis_t               ax_c;
  pcns_pkg::axis_t               ay_c;
  pcns_pkg::axis_t               az_c;
  logic                          z_step_c;
  logic [pcns_pkg::COORD_W-1:0]  nl_c;
  logic [12:0]                   plane_prod_c;
  logic [12:0]                   plane_sum_c;
  logic [18:0]                   idx_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r   <= pcns_pkg::RESET_DIVISIONS;
      grid_rows_r   <= pcns_pkg::RESET_DIVISIONS;
      grid_layers_r <= pcns_pkg::RESET_DIVISIONS;
      three_d_r     <= 1'b1;
    end else if (cfg_we) begin
      unique case (pcns_pkg::cfg_index_t'(cfg_index))
        pcns_pkg::CFG_GRID_COLS:   grid_cols_r   <= cfg_wdata;
        pcns_pkg::CFG_GRID_ROWS:   grid_rows_r   <= cfg_wdata;
        pcns_pkg::CFG_GRID_LAYERS: grid_layers_r <= cfg_wdata;
        pcns_pkg::CFG_THREE_D:     three_d_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cols_c = pcns_pkg::clamp_div(grid_cols_r);
  assign rows_c = pcns_pkg::clamp_div(grid_rows_r);
  assign lays_c = pcns_pkg::clamp_div(grid_layers_r);

  assign adv    = !out_valid_r || out_chan.ready;
  assign bad_c  = ({1'b0, col_r} >= cols_c) || ({1'b0, row_r} >= rows_c) ||
                  (three_d_r && ({1'b0, lay_r} >= lays_c));
  assign last_c = bad_c ||
                  (slot_r == (three_d_r ? pcns_pkg::LAST_SLOT_3D : pcns_pkg::LAST_SLOT_2D));
  assign issue  = item_valid_r && adv;
  assign in_chan.ready = !item_valid_r || (adv && last_c);
  assign accept = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (accept) begin
      item_valid_r <= 1'b1;
    end else if (issue && last_c) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_r  <= in_chan.cell_col;
      row_r  <= in_chan.cell_row;
      lay_r  <= in_chan.cell_layer;
      slot_r <= '0;
    end else if (issue) begin
      slot_r <= slot_r + 4'd1;
    end
  end

  assign step_c   = pcns_pkg::stencil_step(slot_r);
  assign ax_c     = pcns_pkg::step_axis(col_r, step_c.xp, step_c.xn, cols_c);
  assign ay_c     = pcns_pkg::step_axis(row_r, step_c.yp, step_c.yn, rows_c);
  assign z_step_c = three_d_r && (slot_r >= pcns_pkg::STENCIL_SIZE_2D);
  assign az_c     = pcns_pkg::step_axis(lay_r, z_step_c, 1'b0, lays_c);
  assign nl_c     = three_d_r ? az_c.pos : '0;
  assign plane_prod_c = 13'(nl_c) * 13'(rows_c);
  assign plane_sum_c  = plane_prod_c + 13'(ay_c.pos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_last_r <= last_c;
      a_bad_r  <= bad_c;
      if (bad_c) begin
        a_slot_r  <= '0;
        a_nc_r    <= '0;
        a_plane_r <= '0;
        a_wx_r    <= pcns_pkg::WRAP_NONE;
        a_wy_r    <= pcns_pkg::WRAP_NONE;
        a_wz_r    <= pcns_pkg::WRAP_NONE;
      end else begin
        a_slot_r  <= slot_r;
        a_nc_r    <= ax_c.pos;
        a_plane_r <= plane_sum_c[pcns_pkg::PLANE_W-1:0];
        a_wx_r    <= ax_c.wrap;
        a_wy_r    <= ay_c.wrap;
        a_wz_r    <= three_d_r ? az_c.wrap : pcns_pkg::WRAP_NONE;
      end
    end
  end

  assign idx_c = 19'(a_plane_r) * 19'(cols_c) + 19'(a_nc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_slot_r <= a_slot_r;
      out_cell_r <= idx_c[pcns_pkg::CELL_W-1:0];
      out_wx_r   <= a_wx_r;
      out_wy_r   <= a_wy_r;
      out_wz_r   <= a_wz_r;
      out_last_r <= a_last_r;
      out_bad_r  <= a_bad_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.slot           = out_slot_r;
  assign out_chan.neighbor_cell  = out_cell_r;
  assign out_chan.wrap_x         = out_wx_r;
  assign out_chan.wrap_y         = out_wy_r;
  assign out_chan.wrap_z         = out_wz_r;
  assign out_chan.last           = out_last_r;
  assign out_chan.bad_coordinate = out_bad_r;

`ifndef SYNTHESIS
  a_bad_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_last_r && (out_slot_r == '0))
    else $error("bad coordinate result is not a single slot-zero result");

  a_slot_2d : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !three_d_r |-> out_slot_r <= pcns_pkg::LAST_SLOT_2D)
    else $error("2D stencil slot out of range");

  a_slot_seq : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_chan.ready && !out_last_r |=>
      out_valid_r && (out_slot_r == $past(out_slot_r) + 4'd1))
    else $error("stencil slots not issued back to back in order");

  a_wrap_z : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_wz_r != pcns_pkg::WRAP_NONE) |->
      three_d_r && (out_slot_r >= pcns_pkg::STENCIL_SIZE_2D))
    else $error("z wrap outside the upper layer slots");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the periodic cell neighbor stencil core. Home
// cells are sent through the request channel under a series of grid
// settings, and every neighbor result is compared field by field against a
// behavioral prediction of the half-shell stencil with periodic wrap.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int MAX_REPORTS    = 10;
  localparam int LONG_HOLD      = 300;
  localparam int GRID_MAX       = 64;
  localparam int COORD_MAX      = 63;

  localparam int STEP_X [13] = '{1, 1, 0, -1, 1, 1, 0, -1, -1, -1, 0, 1, 0};
  localparam int STEP_Y [13] = '{0, 1, 1, 1, 0, 1, 1, 1, 0, -1, -1, -1, 0};

  typedef struct {
    logic [pcns_pkg::SLOT_W-1:0]        slot;
    logic [pcns_pkg::CELL_W-1:0]        nbr_cell;
    logic signed [pcns_pkg::WRAP_W-1:0] wx;
    logic signed [pcns_pkg::WRAP_W-1:0] wy;
    logic signed [pcns_pkg::WRAP_W-1:0] wz;
    logic                               last;
    logic                               bad;
  } neighbor_t;

  typedef struct {
    logic [pcns_pkg::COORD_W-1:0] col;
    logic [pcns_pkg::COORD_W-1:0] row;
    logic [pcns_pkg::COORD_W-1:0] layer;
  } home_cell_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [1:0]                  cfg_index;
  logic [pcns_pkg::DIV_W-1:0]  cfg_wdata;

  pcns_in_if  in_chan ();
  pcns_out_if out_chan ();

  periodic_cell_neighbor_stencil_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  int cols_reg;
  int rows_reg;
  int layers_reg;
  int three_d_reg;

  home_cell_t home_queue[$];
  neighbor_t  neighbor_queue[$];

  int cells_queued;
  int cells_taken;
  int results_seen;
  int bad_seen;
  int mismatches;
  int idle_cycles;
  int grid_settings;
  int in_gap;
  int out_stall;
  bit gaps_on;
  bit hold_long;
  logic in_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int wrap_step(input int pos, input int dir, input int n,
                                   output int wrap);
    wrap = 0;
    if (dir > 0) begin
      if (pos + 1 >= n) begin
        wrap = -1;
        return 0;
      end
      return pos + 1;
    end
    if (dir < 0) begin
      if (pos == 0) begin
        wrap = 1;
        return n - 1;
      end
      return pos - 1;
    end
    return pos;
  endfunction

  function automatic void predict_neighbors(input home_cell_t h);
    int cols;
    int rows;
    int lays;
    int count;
    int nc;
    int nr;
    int nl;
    int wx;
    int wy;
    int wz;
    neighbor_t r;
    cols  = (cols_reg > GRID_MAX) ? GRID_MAX : cols_reg;
    rows  = (rows_reg > GRID_MAX) ? GRID_MAX : rows_reg;
    lays  = (layers_reg > GRID_MAX) ? GRID_MAX : layers_reg;
    count = (three_d_reg != 0) ? int'(pcns_pkg::STENCIL_SIZE_3D) :
                                 int'(pcns_pkg::STENCIL_SIZE_2D);
    if (h.col >= cols || h.row >= rows || (three_d_reg != 0 && h.layer >= lays)) begin
      r.slot     = '0;
      r.nbr_cell = '0;
      r.wx       = '0;
      r.wy       = '0;
      r.wz       = '0;
      r.last     = 1'b1;
      r.bad      = 1'b1;
      neighbor_queue.push_back(r);
      return;
    end
    for (int s = 0; s < count; s++) begin
      nc = wrap_step(h.col, STEP_X[s], cols, wx);
      nr = wrap_step(h.row, STEP_Y[s], rows, wy);
      nl = (three_d_reg != 0) ? int'(h.layer) : 0;
      wz = 0;
      if (three_d_reg != 0 && s >= int'(pcns_pkg::STENCIL_SIZE_2D)) begin
        nl = wrap_step(nl, 1, lays, wz);
      end
      r.slot     = s[pcns_pkg::SLOT_W-1:0];
      r.nbr_cell = pcns_pkg::CELL_W'(nl * cols * rows + nr * cols + nc);
      r.wx       = wx[pcns_pkg::WRAP_W-1:0];
      r.wy       = wy[pcns_pkg::WRAP_W-1:0];
      r.wz       = wz[pcns_pkg::WRAP_W-1:0];
      r.last     = (s == count - 1);
      r.bad      = 1'b0;
      neighbor_queue.push_back(r);
    end
  endfunction

  function automatic int rand_coord(input int n);
    int lim;
    lim = (n > GRID_MAX) ? GRID_MAX : n;
    if (lim == 0 || $urandom_range(0, 9) == 0) begin
      return $urandom_range(0, COORD_MAX);
    end
    return $urandom_range(0, lim - 1);
  endfunction

  // Request and result handshakes are both sampled here at the rising edge.
  always @(posedge clk) begin
    home_cell_t h;
    neighbor_t  exp_r;
    in_taken <= rst_n && in_chan.valid && in_chan.ready;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      h.col   = in_chan.cell_col;
      h.row   = in_chan.cell_row;
      h.layer = in_chan.cell_layer;
      predict_neighbors(h);
      cells_taken++;
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (out_chan.bad_coordinate) begin
        bad_seen++;
      end
      if (neighbor_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected neighbor result: slot %0d cell %0d", out_chan.slot,
                   out_chan.neighbor_cell);
        end
      end else begin
        exp_r = neighbor_queue.pop_front();
        if (out_chan.slot !== exp_r.slot || out_chan.neighbor_cell !== exp_r.nbr_cell ||
            out_chan.wrap_x !== exp_r.wx || out_chan.wrap_y !== exp_r.wy ||
            out_chan.wrap_z !== exp_r.wz || out_chan.last !== exp_r.last ||
            out_chan.bad_coordinate !== exp_r.bad) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display({"neighbor mismatch: expected slot %0d cell %0d wrap %0d/%0d/%0d",
                      " last %0b bad %0b"},
                     exp_r.slot, exp_r.nbr_cell, exp_r.wx, exp_r.wy, exp_r.wz, exp_r.last,
                     exp_r.bad);
            $display({"                   got      slot %0d cell %0d wrap %0d/%0d/%0d",
                      " last %0b bad %0b"},
                     out_chan.slot, out_chan.neighbor_cell, out_chan.wrap_x,
                     out_chan.wrap_y, out_chan.wrap_z, out_chan.last,
                     out_chan.bad_coordinate);
          end
        end
      end
    end
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", neighbor_queue.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    home_cell_t h;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (in_chan.valid && !in_taken) begin
    end else if (in_gap > 0) begin
      in_gap--;
      in_chan.valid <= 1'b0;
    end else if (home_queue.size() > 0 && gaps_on && $urandom_range(0, 5) == 0) begin
      in_gap = $urandom_range(0, 10);
      in_chan.valid <= 1'b0;
    end else if (home_queue.size() > 0) begin
      h = home_queue.pop_front();
      in_chan.valid      <= 1'b1;
      in_chan.cell_col   <= h.col;
      in_chan.cell_row   <= h.row;
      in_chan.cell_layer <= h.layer;
    end else begin
      in_chan.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n || hold_long) begin
      out_chan.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_chan.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      out_stall = $urandom_range(0, 10);
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  task automatic send_cell(input int col, input int row, input int layer);
    home_cell_t h;
    h.col   = col[pcns_pkg::COORD_W-1:0];
    h.row   = row[pcns_pkg::COORD_W-1:0];
    h.layer = layer[pcns_pkg::COORD_W-1:0];
    home_queue.push_back(h);
    cells_queued++;
  endtask

  task automatic settle();
    while (cells_taken != cells_queued || neighbor_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input pcns_pkg::cfg_index_t idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[pcns_pkg::DIV_W-1:0];
  endtask

  task automatic set_grid(input int cols, input int rows, input int lays, input int td);
    settle();
    write_reg(pcns_pkg::CFG_GRID_COLS, cols);
    write_reg(pcns_pkg::CFG_GRID_ROWS, rows);
    write_reg(pcns_pkg::CFG_GRID_LAYERS, lays);
    write_reg(pcns_pkg::CFG_THREE_D, td);
    @(negedge clk);
    cfg_we      <= 1'b0;
    cols_reg    = cols & 127;
    rows_reg    = rows & 127;
    layers_reg  = lays & 127;
    three_d_reg = td & 1;
    grid_settings++;
  endtask

  task automatic random_grid();
    int dims[3];
    foreach (dims[i]) begin
      dims[i] = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 127) :
                                               $urandom_range(1, GRID_MAX);
    end
    set_grid(dims[0], dims[1], dims[2], $urandom_range(0, 3) != 0);
  endtask

  task automatic random_cells(input int count);
    repeat (count) begin
      send_cell(rand_coord(cols_reg), rand_coord(rows_reg),
                (three_d_reg != 0) ? rand_coord(layers_reg) : $urandom_range(0, COORD_MAX));
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = pcns_pkg::CFG_GRID_COLS;
    cfg_wdata          = '0;
    in_chan.valid      = 1'b0;
    in_chan.cell_col   = '0;
    in_chan.cell_row   = '0;
    in_chan.cell_layer = '0;
    out_chan.ready     = 1'b0;
    in_taken           = 1'b0;
    gaps_on            = 1'b1;
    hold_long          = 1'b0;
    in_gap             = 0;
    out_stall          = 0;
    cells_queued       = 0;
    cells_taken        = 0;
    results_seen       = 0;
    bad_seen           = 0;
    mismatches         = 0;
    idle_cycles        = 0;
    grid_settings      = 1;
    cols_reg           = int'(pcns_pkg::RESET_DIVISIONS);
    rows_reg           = int'(pcns_pkg::RESET_DIVISIONS);
    layers_reg         = int'(pcns_pkg::RESET_DIVISIONS);
    three_d_reg        = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Grid left at its reset size: corners, edges and each axis out of range.
    send_cell(0, 0, 0);
    send_cell(3, 3, 3);
    send_cell(3, 0, 3);
    send_cell(0, 3, 0);
    send_cell(4, 0, 0);
    send_cell(0, 4, 0);
    send_cell(0, 0, 4);
    send_cell(63, 63, 63);

    // A single division on every axis wraps each step back onto itself.
    set_grid(1, 1, 1, 1);
    send_cell(0, 0, 0);
    send_cell(1, 0, 0);

    set_grid(64, 64, 64, 1);
    send_cell(63, 63, 63);
    send_cell(0, 0, 0);
    send_cell(63, 0, 63);

    set_grid(0, 4, 4, 1);
    send_cell(0, 0, 0);

    // Sizes above the maximum are clamped to it.
    set_grid(127, 65, 100, 1);
    send_cell(63, 63, 63);
    send_cell(0, 0, 0);

    // In 2D the layer is ignored, even with a zero layer count.
    set_grid(5, 3, 0, 0);
    send_cell(4, 2, 63);
    send_cell(0, 0, 9);
    send_cell(5, 0, 0);

    set_grid(64, 64, 1, 0);
    send_cell(63, 63, 0);
    send_cell(0, 63, 5);

    for (int p = 0; p < 8; p++) begin
      random_grid();
      gaps_on = (p != 2);
      if (p == 3) begin
        fork
          begin
            @(posedge clk);
            hold_long = 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            hold_long = 1'b0;
          end
        join_none
      end
      random_cells(35);
    end

    random_grid();
    gaps_on = 1'b0;
    random_cells(30);
    settle();

    $display("Sent %0d home cells under %0d grid settings, checked %0d neighbor results.",
             cells_taken, grid_settings, results_seen);
    $display("Of those, %0d were out-of-grid errors; %0d mismatches were found.",
             bad_seen, mismatches);
    if (mismatches == 0 && neighbor_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
